@@ rtl/rfr_pkg.sv @@
// ----------------------------------------------------------------------------
// rfr_pkg: shared definitions for the serial frame receiver
// Constants, register indexes and the command/status bundles that join the
// controller and the datapath.
// ----------------------------------------------------------------------------
package rfr_pkg;

  localparam int MAX_PAYLOAD = 32;
  localparam int PTR_W       = $clog2(MAX_PAYLOAD);
  localparam int LEN_W       = 6;
  localparam int BYTE_W      = 8;
  localparam int IDX_W       = 5;
  localparam int CFG_IDX_W   = 2;

  localparam logic [BYTE_W-1:0] BROADCAST_ADDR = 8'hFF;

  localparam logic [BYTE_W-1:0] HEADER_RESET   = 8'hAA;
  localparam logic [BYTE_W-1:0] FOOTER_RESET   = 8'h55;
  localparam logic [BYTE_W-1:0] NODE_RESET     = 8'h01;
  localparam logic [LEN_W-1:0]  MAX_LEN_RESET  = LEN_W'(MAX_PAYLOAD);
  localparam logic [LEN_W-1:0]  MAX_LEN_CAP    = LEN_W'(MAX_PAYLOAD);

  localparam logic [CFG_IDX_W-1:0] REG_HEADER  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FOOTER  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NODE    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN = 2'd3;

  // Controller to datapath.
  typedef struct packed {
    logic load_addr;
    logic load_cmd;
    logic load_len;
    logic store_payload;
    logic load_check;
    logic set_pending;
    logic clear_pending;
    logic emit_start;
    logic read;
    logic advance;
  } ctrl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic hdr_match;
    logic addr_ok;
    logic len_ok;
    logic len_zero;
    logic payload_done;
    logic frame_good;
    logic emit_last;
  } dp_status_t;

endpackage

@@ rtl/rfr_ram.sv @@
// ----------------------------------------------------------------------------
// rfr_ram: generic simple dual-port RAM
// One write port and one read port with registered, enabled read data.
// ----------------------------------------------------------------------------
module rfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/rfr_datapath.sv @@
// ----------------------------------------------------------------------------
// rfr_datapath: frame field registers, checksum and payload store
// Holds configuration, captured header fields, the running XOR, the pending
// flag and the delivery index, and reports comparisons to the controller.
// ----------------------------------------------------------------------------
module rfr_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [rfr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rfr_pkg::BYTE_W-1:0]        cfg_data,
  input  logic [rfr_pkg::BYTE_W-1:0]        data_byte,
  input  rfr_pkg::ctrl_cmd_t                cmd,
  output rfr_pkg::dp_status_t               status,
  output logic [rfr_pkg::BYTE_W-1:0]        frame_address,
  output logic [rfr_pkg::BYTE_W-1:0]        frame_command,
  output logic [rfr_pkg::LEN_W-1:0]         frame_length,
  output logic [rfr_pkg::BYTE_W-1:0]        payload_byte,
  output logic [rfr_pkg::IDX_W-1:0]         byte_index,
  output logic                              last
);

  logic [rfr_pkg::BYTE_W-1:0] header_byte;
  logic [rfr_pkg::BYTE_W-1:0] footer_byte;
  logic [rfr_pkg::BYTE_W-1:0] node_address;
  logic [rfr_pkg::LEN_W-1:0]  max_payload;

  logic [rfr_pkg::BYTE_W-1:0] held_address;
  logic [rfr_pkg::BYTE_W-1:0] held_command;
  logic [rfr_pkg::LEN_W-1:0]  held_length;
  logic [rfr_pkg::LEN_W-1:0]  payload_count;
  logic [rfr_pkg::BYTE_W-1:0] running_xor;
  logic [rfr_pkg::BYTE_W-1:0] received_check;
  logic                       frame_pending;
  logic [rfr_pkg::LEN_W-1:0]  emit_idx;

  logic [rfr_pkg::LEN_W-1:0]  length_limit;
  logic [rfr_pkg::LEN_W:0]    count_plus;
  logic [rfr_pkg::LEN_W-1:0]  idx_plus;
  logic [rfr_pkg::BYTE_W-1:0] rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_byte  <= rfr_pkg::HEADER_RESET;
      footer_byte  <= rfr_pkg::FOOTER_RESET;
      node_address <= rfr_pkg::NODE_RESET;
      max_payload  <= rfr_pkg::MAX_LEN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        rfr_pkg::REG_HEADER:  header_byte  <= cfg_data;
        rfr_pkg::REG_FOOTER:  footer_byte  <= cfg_data;
        rfr_pkg::REG_NODE:    node_address <= cfg_data;
        rfr_pkg::REG_MAX_LEN: max_payload  <= cfg_data[rfr_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign length_limit = (max_payload > rfr_pkg::MAX_LEN_CAP) ? rfr_pkg::MAX_LEN_CAP
                                                             : max_payload;
  assign count_plus   = {1'b0, payload_count} + 1'b1;
  assign idx_plus     = emit_idx + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_address   <= '0;
      held_command   <= '0;
      held_length    <= '0;
      payload_count  <= '0;
      running_xor    <= '0;
      received_check <= '0;
      frame_pending  <= 1'b0;
      emit_idx       <= '0;
    end else begin
      if (cmd.load_addr) begin
        held_address <= data_byte;
        running_xor  <= data_byte;
      end
      if (cmd.load_cmd) begin
        held_command <= data_byte;
        running_xor  <= running_xor ^ data_byte;
      end
      if (cmd.load_len) begin
        held_length   <= data_byte[rfr_pkg::LEN_W-1:0];
        payload_count <= '0;
        running_xor   <= running_xor ^ data_byte;
      end
      if (cmd.store_payload) begin
        payload_count <= count_plus[rfr_pkg::LEN_W-1:0];
        running_xor   <= running_xor ^ data_byte;
      end
      if (cmd.load_check) begin
        received_check <= data_byte;
      end
      if (cmd.set_pending) begin
        frame_pending <= 1'b1;
      end else if (cmd.clear_pending) begin
        frame_pending <= 1'b0;
      end
      if (cmd.emit_start) begin
        emit_idx <= '0;
      end else if (cmd.advance) begin
        emit_idx <= idx_plus;
      end
    end
  end

  rfr_ram #(
    .WIDTH(rfr_pkg::BYTE_W),
    .DEPTH(rfr_pkg::MAX_PAYLOAD)
  ) u_store (
    .clk  (clk),
    .we   (cmd.store_payload),
    .waddr(payload_count[rfr_pkg::PTR_W-1:0]),
    .wdata(data_byte),
    .re   (cmd.read),
    .raddr(emit_idx[rfr_pkg::PTR_W-1:0]),
    .rdata(rdata)
  );

  always_comb begin
    status.hdr_match    = (data_byte == header_byte);
    status.addr_ok      = (data_byte == node_address) ||
                          (data_byte == rfr_pkg::BROADCAST_ADDR);
    status.len_ok       = (data_byte <= {2'b00, length_limit});
    status.len_zero     = (data_byte == '0);
    status.payload_done = (count_plus >= {1'b0, held_length});
    status.frame_good   = (data_byte == footer_byte) &&
                          (running_xor == received_check) && !frame_pending;
    status.emit_last    = (held_length == '0) || (idx_plus == held_length);
  end

  assign frame_address = held_address;
  assign frame_command = held_command;
  assign frame_length  = held_length;
  assign payload_byte  = (held_length == '0) ? '0 : rdata;
  assign byte_index    = emit_idx[rfr_pkg::IDX_W-1:0];
  assign last          = status.emit_last;

endmodule

@@ rtl/rfr_ctrl.sv @@
// ----------------------------------------------------------------------------
// rfr_ctrl: frame parser and delivery state machine
// Steps through the frame fields one received byte at a time and then
// sequences the reads of the payload store for result delivery.
// ----------------------------------------------------------------------------
module rfr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                action,
  input  logic                out_ready,
  input  rfr_pkg::dp_status_t status,
  output logic                in_ready,
  output logic                out_valid,
  output rfr_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_HEADER,
    S_ADDRESS,
    S_COMMAND,
    S_LENGTH,
    S_PAYLOAD,
    S_CHECK,
    S_FOOTER,
    S_READ,
    S_SHOW
  } state_t;

  state_t state;
  logic   accept;
  logic   byte_acc;

  assign in_ready  = (state != S_READ) && (state != S_SHOW);
  assign out_valid = (state == S_SHOW);
  assign accept    = in_valid && in_ready;
  assign byte_acc  = accept && !action;

  always_comb begin
    cmd = '0;
    cmd.clear_pending = accept && action;
    case (state)
      S_ADDRESS: cmd.load_addr     = byte_acc && status.addr_ok;
      S_COMMAND: cmd.load_cmd      = byte_acc;
      S_LENGTH:  cmd.load_len      = byte_acc && status.len_ok;
      S_PAYLOAD: cmd.store_payload = byte_acc;
      S_CHECK:   cmd.load_check    = byte_acc;
      S_FOOTER: begin
        cmd.set_pending = byte_acc && status.frame_good;
        cmd.emit_start  = byte_acc && status.frame_good;
      end
      S_READ:    cmd.read          = 1'b1;
      S_SHOW:    cmd.advance       = out_ready && !status.emit_last;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_HEADER;
    end else begin
      case (state)
        S_HEADER: begin
          if (byte_acc && status.hdr_match) state <= S_ADDRESS;
        end
        S_ADDRESS: begin
          if (byte_acc) state <= status.addr_ok ? S_COMMAND : S_HEADER;
        end
        S_COMMAND: begin
          if (byte_acc) state <= S_LENGTH;
        end
        S_LENGTH: begin
          if (byte_acc) begin
            if (!status.len_ok) state <= S_HEADER;
            else if (status.len_zero) state <= S_CHECK;
            else state <= S_PAYLOAD;
          end
        end
        S_PAYLOAD: begin
          if (byte_acc && status.payload_done) state <= S_CHECK;
        end
        S_CHECK: begin
          if (byte_acc) state <= S_FOOTER;
        end
        S_FOOTER: begin
          if (byte_acc) state <= status.frame_good ? S_READ : S_HEADER;
        end
        S_READ: begin
          state <= S_SHOW;
        end
        S_SHOW: begin
          if (out_ready) state <= status.emit_last ? S_HEADER : S_READ;
        end
        default: begin
          state <= S_HEADER;
        end
      endcase
    end
  end

endmodule

@@ rtl/rs485_frame_receiver.sv @@
// ----------------------------------------------------------------------------
// rs485_frame_receiver: serial frame parser with XOR checksum
// Parses header/address/command/length/payload/checksum/footer frames and
// delivers each good frame as a run of payload results.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid/in_ready) carries one item per received
// byte (action 0) or a consume item (action 1) that releases a pending frame.
// Every input item is taken as soon as it is valid while the block parses, so
// bytes may arrive back to back. Consume items are accepted at any parse step
// and do not disturb the parser.
// When the footer of a good frame is accepted and no frame is pending, the
// block stops taking input and delivers the frame on the output channel
// (out_valid/out_ready): one result per payload byte, or a single result
// with payload_byte 0 for an empty payload. For each result the block first
// reads the payload store (S_READ) and then presents the result (S_SHOW),
// so the first result is offered once the footer is taken and the first
// store read is done; the registered store read sets this pace for every
// result, whether the payload has bytes or is empty.
// If the receiver holds out_ready low, the current result stays on the
// output unchanged and input remains stalled until the last result is taken.
// Bad frames are dropped with no result. Reset (rst, synchronous) restores
// the register defaults, clears the pending flag and returns the parser to
// waiting for a header; the payload store needs no clearing.
// ----------------------------------------------------------------------------
module rs485_frame_receiver (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [rfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rfr_pkg::BYTE_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          action,
  input  logic [rfr_pkg::BYTE_W-1:0]    data_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rfr_pkg::BYTE_W-1:0]    frame_address,
  output logic [rfr_pkg::BYTE_W-1:0]    frame_command,
  output logic [rfr_pkg::LEN_W-1:0]     frame_length,
  output logic [rfr_pkg::BYTE_W-1:0]    payload_byte,
  output logic [rfr_pkg::IDX_W-1:0]     byte_index,
  output logic                          last
);

  // The controller and the datapath talk only through these two bundles.
  rfr_pkg::ctrl_cmd_t  cmd;
  rfr_pkg::dp_status_t status;

  rfr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .action   (action),
    .out_ready(out_ready),
    .status   (status),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .cmd      (cmd)
  );

  // The datapath holds every field register, the checksum and the store.
  rfr_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .data_byte    (data_byte),
    .cmd          (cmd),
    .status       (status),
    .frame_address(frame_address),
    .frame_command(frame_command),
    .frame_length (frame_length),
    .payload_byte (payload_byte),
    .byte_index   (byte_index),
    .last         (last)
  );

endmodule

@@ rtl/rfr_checker.sv @@
// ----------------------------------------------------------------------------
// rfr_checker: port-level checks for the frame receiver
// Watches the top-level ports and is attached by a bind statement.
// ----------------------------------------------------------------------------
module rfr_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [rfr_pkg::LEN_W-1:0]     frame_length,
  input logic [rfr_pkg::BYTE_W-1:0]    payload_byte,
  input logic [rfr_pkg::IDX_W-1:0]     byte_index,
  input logic                          last
);

  // Input is never taken while a result is on offer.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input ready while a result is offered");

  // A stalled result keeps its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(payload_byte) &&
                                $stable(byte_index))
    else $error("stalled result changed");

  // After a result that is not the last, the block keeps delivering.
  a_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=> !in_ready)
    else $error("frame delivery ended early");

  // The last result of a frame sits at the end of the payload.
  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |->
      ((frame_length == '0) && (byte_index == '0)) ||
      ({1'b0, byte_index} + 1'b1 == frame_length))
    else $error("last flag at the wrong position");

  // Every result index lies inside the payload.
  a_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && (frame_length != '0) |-> ({1'b0, byte_index} < frame_length))
    else $error("byte index beyond the payload");

endmodule

bind rs485_frame_receiver rfr_checker u_rfr_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .frame_length(frame_length),
  .payload_byte(payload_byte),
  .byte_index  (byte_index),
  .last        (last)
);
